[rtl/core/iwa_pkg.sv]
// shared widths, request codes and controller/datapath bundles
package iwa_pkg;

    localparam int POS_W = 31;
    localparam int VAL_W = 32;
    localparam int SW_W  = 21;
    localparam int CNT_W = 31;
    localparam int SUM_W = 64;
    localparam int WIN_W = 33;

    localparam logic [1:0] MODE_WIN = 2'd0;
    localparam logic [1:0] MODE_SIG = 2'd1;
    localparam logic [1:0] MODE_FIN = 2'd2;

    typedef struct packed {
        logic capture;
        logic set_win;
        logic add_size;
        logic clip;
        logic mul;
        logic add_sum;
        logic div_start;
        logic div_sel;
        logic take_all;
        logic take_cov;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

[rtl/core/iwa_if.sv]
// request and result channel interfaces
interface iwa_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic [iwa_pkg::POS_W-1:0]           pos_a;
    logic [iwa_pkg::POS_W-1:0]           pos_b;
    logic signed [iwa_pkg::VAL_W-1:0]    sample_value;

    modport source (output valid, mode, pos_a, pos_b, sample_value, input ready);
    modport sink   (input valid, mode, pos_a, pos_b, sample_value, output ready);
endinterface

interface iwa_out_if;
    logic                                valid;
    logic                                ready;
    logic [iwa_pkg::CNT_W-1:0]           total_size;
    logic [iwa_pkg::CNT_W-1:0]           covered;
    logic signed [iwa_pkg::SUM_W-1:0]    signal_sum;
    logic signed [iwa_pkg::VAL_W-1:0]    mean_all;
    logic signed [iwa_pkg::VAL_W-1:0]    mean_covered;
    logic signed [iwa_pkg::VAL_W-1:0]    min_val;
    logic signed [iwa_pkg::VAL_W-1:0]    max_val;
    logic                                empty_size;

    modport source (output valid, total_size, covered, signal_sum, mean_all, mean_covered,
                    min_val, max_val, empty_size, input ready);
    modport sink   (input valid, total_size, covered, signal_sum, mean_all, mean_covered,
                    min_val, max_val, empty_size, output ready);
endinterface

[rtl/core/interval_weighted_average.sv]
// top level: weighted signal average over the windows of one region
//
//  channel   dir  handshake          contents
//  i_in      in   valid/ready        mode, pos_a, pos_b, sample_value
//  o_out     out  valid/ready        region totals, means, min/max, empty flag
//  i_cfg_*   in   write enable only  sample_width
//
// one request at a time; mode 0 captures, places the window and adds its size;
// mode 1 captures, clips, multiplies and accumulates; mode 3 is ignored;
// mode 2 runs two 64-step bit-serial divisions on one shared divider
// a finished result sits in the output register while further requests are taken;
// a mode 2 request holds in its last cycle until the previous result is taken
// synchronous active-low reset clears the region accumulators and sample width
module interval_weighted_average (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [iwa_pkg::SW_W-1:0]  i_cfg_wdata,
    iwa_in_if.sink                    i_in,
    iwa_out_if.source                 o_out
);
    import iwa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    iwa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_mode   (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    iwa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_pos_a        (i_in.pos_a),
        .i_pos_b        (i_in.pos_b),
        .i_sample_value (i_in.sample_value),
        .o_total_size   (o_out.total_size),
        .o_covered      (o_out.covered),
        .o_signal_sum   (o_out.signal_sum),
        .o_mean_all     (o_out.mean_all),
        .o_mean_covered (o_out.mean_covered),
        .o_min_val      (o_out.min_val),
        .o_max_val      (o_out.max_val),
        .o_empty_size   (o_out.empty_size)
    );

endmodule

[rtl/core/iwa_div.sv]
// bit-serial signed sum by count divider with int32 saturation
module iwa_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [iwa_pkg::SUM_W-1:0]  i_dividend,
    input  logic [iwa_pkg::CNT_W-1:0]         i_divisor,
    output logic                              o_done,
    output logic signed [iwa_pkg::VAL_W-1:0]  o_quot
);
    import iwa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_neg;
    logic              r_done;

    logic [SUM_W-1:0]  w_mag;
    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    assign w_mag   = i_dividend[SUM_W-1] ? (SUM_W'(0) - i_dividend) : i_dividend;
    assign w_trial = {r_rem, r_q[SUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= STEP_W'(SUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q[SUM_W-1:VAL_W-1] != '0) ? {1'b1, {(VAL_W-1){1'b0}}}
                                                   : (VAL_W'(0) - r_q[VAL_W-1:0]);
        end else begin
            o_quot = (r_q[SUM_W-1:VAL_W-1] != '0) ? {1'b0, {(VAL_W-1){1'b1}}}
                                                   : {1'b0, r_q[VAL_W-2:0]};
        end
    end

    assign o_done = r_done;

endmodule

[rtl/core/iwa_dp.sv]
// window, clipping, accumulator and result register datapath
module iwa_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iwa_pkg::t_cmd                     i_cmd,
    output iwa_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic [iwa_pkg::SW_W-1:0]          i_cfg_wdata,
    input  logic [iwa_pkg::POS_W-1:0]         i_pos_a,
    input  logic [iwa_pkg::POS_W-1:0]         i_pos_b,
    input  logic signed [iwa_pkg::VAL_W-1:0]  i_sample_value,
    output logic [iwa_pkg::CNT_W-1:0]         o_total_size,
    output logic [iwa_pkg::CNT_W-1:0]         o_covered,
    output logic signed [iwa_pkg::SUM_W-1:0]  o_signal_sum,
    output logic signed [iwa_pkg::VAL_W-1:0]  o_mean_all,
    output logic signed [iwa_pkg::VAL_W-1:0]  o_mean_covered,
    output logic signed [iwa_pkg::VAL_W-1:0]  o_min_val,
    output logic signed [iwa_pkg::VAL_W-1:0]  o_max_val,
    output logic                              o_empty_size
);
    import iwa_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic [POS_W-1:0]        r_a;
    logic [POS_W-1:0]        r_b;
    logic signed [VAL_W-1:0] r_val;
    logic [SW_W-1:0]         r_sw;
    logic signed [WIN_W-1:0] r_ws;
    logic signed [WIN_W-1:0] r_we;
    logic [CNT_W-1:0]        r_size;
    logic [CNT_W-1:0]        r_cover;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] r_max;
    logic [CNT_W-1:0]        r_cov;
    logic signed [SUM_W-1:0] r_prod;
    logic signed [VAL_W-1:0] r_m_all;
    logic signed [VAL_W-1:0] r_m_cov;

    logic signed [WIN_W-1:0] n_ws;
    logic signed [WIN_W-1:0] n_we;

    logic [POS_W:0]          w_ab;
    logic [POS_W-1:0]        w_centre;
    logic [SW_W-1:0]         w_half;
    logic [SW_W-1:0]         w_rest;
    logic signed [WIN_W-1:0] w_span;
    logic [CNT_W+1:0]        w_size_sum;
    logic signed [WIN_W-1:0] w_a;
    logic signed [WIN_W-1:0] w_b;
    logic signed [WIN_W-1:0] w_lo;
    logic signed [WIN_W-1:0] w_hi;
    logic signed [WIN_W:0]   w_cov;
    logic                    w_cov_pos;
    logic [CNT_W:0]          w_cov_sum;
    logic signed [SUM_W:0]   w_ss;
    logic signed [VAL_W-1:0] w_quot;
    logic                    w_div_done;

    // window placement
    assign w_ab     = {1'b0, r_a} + {1'b0, r_b};
    assign w_centre = w_ab[POS_W:1];
    assign w_half   = r_sw >> 1;
    assign w_rest   = r_sw - w_half;

    always_comb begin
        if (r_sw != '0) begin
            n_ws = $signed({2'b00, w_centre}) - $signed({{(WIN_W-SW_W){1'b0}}, w_half});
            n_we = $signed({2'b00, w_centre}) + $signed({{(WIN_W-SW_W){1'b0}}, w_rest});
        end else begin
            n_ws = $signed({2'b00, r_a});
            n_we = $signed({2'b00, r_b});
        end
    end

    // size accumulation, reversed window adds nothing
    assign w_span     = r_we - r_ws;
    assign w_size_sum = {2'b00, r_size} +
                        (((!w_span[WIN_W-1]) && (w_span != '0)) ?
                         {1'b0, w_span[CNT_W:0]} : {(CNT_W+2){1'b0}});

    // interval clipping
    assign w_a       = $signed({2'b00, r_a});
    assign w_b       = $signed({2'b00, r_b});
    assign w_lo      = (w_a > r_ws) ? w_a : r_ws;
    assign w_hi      = (w_b < r_we) ? w_b : r_we;
    assign w_cov     = $signed({w_hi[WIN_W-1], w_hi}) - $signed({w_lo[WIN_W-1], w_lo});
    assign w_cov_pos = !w_cov[WIN_W] && (w_cov != '0);

    assign w_cov_sum = {1'b0, r_cover} + {1'b0, r_cov};
    assign w_ss      = $signed({r_sum[SUM_W-1], r_sum}) + $signed({r_prod[SUM_W-1], r_prod});

    iwa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (i_cmd.div_sel ? r_cover : r_size),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_sts.div_done = w_div_done;

    // config and region state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw    <= '0;
            r_ws    <= '0;
            r_we    <= '0;
            r_size  <= '0;
            r_cover <= '0;
            r_sum   <= '0;
            r_min   <= VAL_MAX;
            r_max   <= VAL_MIN;
        end else begin
            if (i_cfg_we) begin
                r_sw <= i_cfg_wdata;
            end
            if (i_cmd.set_win) begin
                r_ws <= n_ws;
                r_we <= n_we;
            end
            if (i_cmd.add_size) begin
                r_size <= (w_size_sum > {2'b00, CNT_MAX}) ? CNT_MAX : w_size_sum[CNT_W-1:0];
            end
            if (i_cmd.mul && (r_cov != '0)) begin
                r_cover <= w_cov_sum[CNT_W] ? CNT_MAX : w_cov_sum[CNT_W-1:0];
                if (r_val > r_max) begin
                    r_max <= r_val;
                end
                if (r_val < r_min) begin
                    r_min <= r_val;
                end
            end
            if (i_cmd.add_sum) begin
                if (w_ss[SUM_W] != w_ss[SUM_W-1]) begin
                    r_sum <= w_ss[SUM_W] ? SUM_MIN : SUM_MAX;
                end else begin
                    r_sum <= w_ss[SUM_W-1:0];
                end
            end
            if (i_cmd.clear) begin
                r_ws    <= '0;
                r_we    <= '0;
                r_size  <= '0;
                r_cover <= '0;
                r_sum   <= '0;
                r_min   <= VAL_MAX;
                r_max   <= VAL_MIN;
            end
        end
    end

    // request capture, working values and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a   <= i_pos_a;
            r_b   <= i_pos_b;
            r_val <= i_sample_value;
        end
        if (i_cmd.clip) begin
            r_cov <= w_cov_pos ? w_cov[CNT_W-1:0] : '0;
        end
        if (i_cmd.mul) begin
            r_prod <= $signed(SUM_W'({1'b0, r_cov})) * SUM_W'(r_val);
        end
        if (i_cmd.take_all) begin
            r_m_all <= w_quot;
        end
        if (i_cmd.take_cov) begin
            r_m_cov <= w_quot;
        end
        if (i_cmd.load_out) begin
            o_total_size   <= r_size;
            o_covered      <= r_cover;
            o_signal_sum   <= r_sum;
            o_mean_all     <= (r_size == '0) ? '0 : r_m_all;
            o_mean_covered <= (r_cover == '0) ? '0 : r_m_cov;
            o_min_val      <= (r_cover == '0) ? '0 : r_min;
            o_max_val      <= (r_cover == '0) ? '0 : r_max;
            o_empty_size   <= (r_size == '0);
        end
    end

endmodule

[rtl/core/iwa_ctrl.sv]
// request sequencing state machine and result valid flag
module iwa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_in_mode,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output iwa_pkg::t_cmd  o_cmd,
    input  iwa_pkg::t_sts  i_sts
);
    import iwa_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WIN  = 4'd1;
    localparam logic [3:0] S_SIZE = 4'd2;
    localparam logic [3:0] S_CLIP = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_DIVA = 4'd6;
    localparam logic [3:0] S_DIVC = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    unique case (i_in_mode)
                        MODE_WIN: n_state = S_WIN;
                        MODE_SIG: n_state = S_CLIP;
                        MODE_FIN: begin
                            w_cmd.div_start = 1'b1;
                            n_state         = S_DIVA;
                        end
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_WIN: begin
                w_cmd.set_win = 1'b1;
                n_state       = S_SIZE;
            end
            S_SIZE: begin
                w_cmd.add_size = 1'b1;
                n_state        = S_IDLE;
            end
            S_CLIP: begin
                w_cmd.clip = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                w_cmd.add_sum = 1'b1;
                n_state       = S_IDLE;
            end
            S_DIVA: begin
                if (i_sts.div_done) begin
                    w_cmd.take_all  = 1'b1;
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = 1'b1;
                    n_state         = S_DIVC;
                end
            end
            S_DIVC: begin
                if (i_sts.div_done) begin
                    w_cmd.take_cov = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    w_cmd.clear    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = w_cmd.load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // divider completions only arrive while a finish request waits on them
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIVA || r_state == S_DIVC))
        else $error("divider done outside division states");

    // the output state is only reached after both quotients
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ($past(r_state) == S_DIVC || $past(r_state) == S_OUT))
        else $error("output state entered without divisions");

endmodule

[sim/interval_weighted_average_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench: directed and random regions checked against a region predictor
module interval_weighted_average_tb;
    import iwa_pkg::*;

    localparam longint POS_MAX = 64'h7FFF_FFFF;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct {
        logic [1:0]               mode;
        logic [POS_W-1:0]         pos_a;
        logic [POS_W-1:0]         pos_b;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct {
        logic [CNT_W-1:0]         total_size;
        logic [CNT_W-1:0]         covered;
        logic signed [SUM_W-1:0]  signal_sum;
        logic signed [VAL_W-1:0]  mean_all;
        logic signed [VAL_W-1:0]  mean_covered;
        logic signed [VAL_W-1:0]  min_val;
        logic signed [VAL_W-1:0]  max_val;
        logic                     empty_size;
    } totals_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [SW_W-1:0]   i_cfg_wdata;

    iwa_in_if  in_ch ();
    iwa_out_if out_ch ();

    interval_weighted_average u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // predictor state
    logic [SW_W-1:0]          width_cfg;
    logic signed [WIN_W-1:0]  win_lo;
    logic signed [WIN_W-1:0]  win_hi;
    logic [CNT_W-1:0]         size_sum;
    logic [CNT_W-1:0]         cover_sum;
    logic signed [SUM_W-1:0]  signal_acc;
    logic signed [VAL_W-1:0]  low_val;
    logic signed [VAL_W-1:0]  high_val;

    req_t     request_q[$];
    totals_t  region_q[$];
    int       req_count;
    int       mismatch_cnt;
    int       idle_pct;
    logic     req_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void clear_region();
        win_lo     = '0;
        win_hi     = '0;
        size_sum   = '0;
        cover_sum  = '0;
        signal_acc = '0;
        low_val    = VAL_MAX;
        high_val   = VAL_MIN;
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] acc, longint add);
        longint s;
        s = acc + add;
        return (s > POS_MAX) ? '1 : s[CNT_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_sum(logic signed [SUM_W-1:0] s,
                                                        logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0] t;
        t = s + v;
        if (t[SUM_W] != t[SUM_W-1])
            return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return t[SUM_W-1:0];
    endfunction

    // truncating divide, saturated to the signed 32-bit integer range
    function automatic logic signed [VAL_W-1:0] div_sat(logic signed [SUM_W-1:0] sum,
                                                        logic [CNT_W-1:0] d);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        mag = sum[SUM_W-1] ? -sum : sum;
        q = mag / d;
        if (sum[SUM_W-1])
            return (q >= 64'h8000_0000) ? VAL_MIN : -q[VAL_W-1:0];
        return (q > 64'h7FFF_FFFF) ? VAL_MAX : q[VAL_W-1:0];
    endfunction

    function automatic void region_step(req_t r);
        longint a;
        longint b;
        longint lo;
        longint hi;
        longint mid;
        longint sw;
        totals_t t;
        a = r.pos_a;
        b = r.pos_b;
        sw = width_cfg;
        case (r.mode)
            MODE_WIN: begin
                if (sw != 0) begin
                    mid = (a + b) / 2;
                    lo = mid - sw / 2;
                    hi = lo + sw;
                end else begin
                    lo = a;
                    hi = b;
                end
                win_lo = WIN_W'(lo);
                win_hi = WIN_W'(hi);
                if (hi > lo)
                    size_sum = sat_count(size_sum, hi - lo);
            end
            MODE_SIG: begin
                lo = (a > win_lo) ? a : win_lo;
                hi = (b < win_hi) ? b : win_hi;
                if (hi > lo) begin
                    cover_sum = sat_count(cover_sum, hi - lo);
                    if (r.value > high_val)
                        high_val = r.value;
                    if (r.value < low_val)
                        low_val = r.value;
                    signal_acc = sat_sum(signal_acc, (hi - lo) * r.value);
                end
            end
            MODE_FIN: begin
                t.total_size   = size_sum;
                t.covered      = cover_sum;
                t.signal_sum   = signal_acc;
                t.mean_all     = (size_sum != 0) ? div_sat(signal_acc, size_sum) : '0;
                t.mean_covered = (cover_sum != 0) ? div_sat(signal_acc, cover_sum) : '0;
                t.min_val      = (cover_sum != 0) ? low_val : '0;
                t.max_val      = (cover_sum != 0) ? high_val : '0;
                t.empty_size   = (size_sum == 0);
                region_q.push_back(t);
                clear_region();
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // request accept and prediction
    always @(posedge i_clk) begin : request_accept
        req_t seen;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            seen.mode  = in_ch.mode;
            seen.pos_a = in_ch.pos_a;
            seen.pos_b = in_ch.pos_b;
            seen.value = in_ch.sample_value;
            region_step(seen);
        end
        req_taken <= i_rst_n && in_ch.valid && in_ch.ready;
    end

    always @(negedge i_clk) begin : request_drive
        req_t nxt;
        if (!in_ch.valid || req_taken) begin
            if (request_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = request_q.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.mode         <= nxt.mode;
                in_ch.pos_a        <= nxt.pos_a;
                in_ch.pos_b        <= nxt.pos_b;
                in_ch.sample_value <= nxt.value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        totals_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (region_q.size() == 0) begin
                report_mismatch("result with no request pending");
            end else begin
                want = region_q.pop_front();
                compare_field("total_size", out_ch.total_size, want.total_size);
                compare_field("covered", out_ch.covered, want.covered);
                compare_field("signal_sum", out_ch.signal_sum, want.signal_sum);
                compare_field("mean_all", out_ch.mean_all, want.mean_all);
                compare_field("mean_covered", out_ch.mean_covered, want.mean_covered);
                compare_field("min_val", out_ch.min_val, want.min_val);
                compare_field("max_val", out_ch.max_val, want.max_val);
                compare_field("empty_size", out_ch.empty_size, want.empty_size);
            end
        end
    end

    function automatic longint rand_pos();
        return longint'($urandom_range(32'h7FFF_FFFF, 0));
    endfunction

    function automatic longint clamp_pos(longint x);
        return (x < 0) ? 0 : (x > POS_MAX) ? POS_MAX : x;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_req(logic [1:0] mode, longint a, longint b,
                            logic signed [VAL_W-1:0] v);
        req_t r;
        r.mode  = mode;
        r.pos_a = a[POS_W-1:0];
        r.pos_b = b[POS_W-1:0];
        r.value = v;
        request_q.push_back(r);
        if (mode != MODE_NONE)
            req_count++;
    endtask

    task automatic gen_region();
        int nwin;
        int nsig;
        longint a;
        longint b;
        longint len;
        longint lo;
        longint hi;
        longint span;
        longint ia;
        longint ib;
        nwin = ($urandom_range(15) == 0) ? 0 : $urandom_range(3, 1);
        if ($urandom_range(7) == 0)
            push_req(MODE_SIG, rand_pos(), rand_pos(), pick_value());
        for (int w = 0; w < nwin; w++) begin
            case ($urandom_range(11))
                0: begin
                    a = rand_pos();
                    b = rand_pos();
                end
                1: begin
                    a = rand_pos();
                    b = clamp_pos(a - $urandom_range(500, 1));
                end
                2: begin
                    a = $urandom_range(1000);
                    b = POS_MAX - $urandom_range(1000);
                end
                default: begin
                    len = ($urandom_range(4) == 0) ? $urandom_range(1 << 20, 1)
                                                  : $urandom_range(300, 1);
                    a = $urandom_range(32'h7FFF_FFFF - len[31:0]);
                    if ($urandom_range(3) == 0)
                        a = $urandom_range(2000);
                    b = a + len;
                end
            endcase
            push_req(MODE_WIN, a, b, pick_value());
            if (width_cfg != 0) begin
                lo = (a + b) / 2 - width_cfg / 2;
                hi = lo + width_cfg;
            end else begin
                lo = a;
                hi = b;
            end
            span = (hi > lo) ? hi - lo : 1;
            if (span > POS_MAX)
                span = POS_MAX;
            nsig = $urandom_range(5);
            for (int s = 0; s < nsig; s++) begin
                if ($urandom_range(7) == 0) begin
                    ia = rand_pos();
                    ib = rand_pos();
                end else begin
                    ia = clamp_pos(lo - span / 4 + $urandom_range(span + span / 2));
                    ib = clamp_pos(ia + $urandom_range(span));
                end
                push_req(MODE_SIG, ia, ib, pick_value());
                if ($urandom_range(9) == 0)
                    push_req(MODE_NONE, rand_pos(), rand_pos(), $urandom());
            end
        end
        push_req(MODE_FIN, rand_pos(), rand_pos(), $urandom());
    endtask

    task automatic run_random(int target);
        int start;
        start = req_count;
        while (req_count - start < target)
            gen_region();
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (request_q.size() != 0 || in_ch.valid || region_q.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_width(logic [SW_W-1:0] w);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        width_cfg = w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_WIN;
        in_ch.pos_a        = '0;
        in_ch.pos_b        = '0;
        in_ch.sample_value = '0;
        out_ch.ready       = 1'b0;
        req_taken          = 1'b0;
        req_count          = 0;
        mismatch_cnt       = 0;
        idle_pct           = 26;
        width_cfg          = '0;
        clear_region();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // interval with no window, ignored mode, empty region
        push_req(MODE_SIG, 0, 100, 5);
        push_req(MODE_NONE, POS_MAX, POS_MAX, VAL_MIN);
        push_req(MODE_FIN, 0, 0, 0);
        // reversed window
        push_req(MODE_WIN, 500, 100, 0);
        push_req(MODE_SIG, 0, 1000, 1);
        push_req(MODE_FIN, POS_MAX, 0, VAL_MAX);
        // count and sum saturation, positive
        push_req(MODE_WIN, 0, POS_MAX, 0);
        push_req(MODE_WIN, 0, POS_MAX, 0);
        push_req(MODE_SIG, 0, POS_MAX, VAL_MAX);
        push_req(MODE_SIG, 0, POS_MAX, VAL_MAX);
        push_req(MODE_SIG, 0, POS_MAX, VAL_MAX);
        push_req(MODE_FIN, 0, 0, 0);
        // sum saturation, negative
        push_req(MODE_WIN, 0, POS_MAX, 0);
        push_req(MODE_SIG, 0, POS_MAX, VAL_MIN);
        push_req(MODE_SIG, 0, POS_MAX, VAL_MIN);
        push_req(MODE_SIG, 0, POS_MAX, VAL_MIN);
        push_req(MODE_FIN, 0, 0, 0);
        // one-base window, mean over size saturates
        push_req(MODE_WIN, 10, 11, 0);
        push_req(MODE_SIG, 0, 20, VAL_MAX);
        push_req(MODE_SIG, 10, 11, VAL_MAX);
        push_req(MODE_SIG, 5, 15, -7);
        push_req(MODE_FIN, 0, 0, 0);
        // window cleared by finish
        push_req(MODE_SIG, 0, POS_MAX, 1);
        push_req(MODE_FIN, 0, 0, 0);

        wait_idle();
        run_random(300);
        write_width(21'd1048576);
        run_random(300);
        write_width(21'd1);
        run_random(250);
        write_width(SW_W'($urandom_range(1048575, 2)));
        run_random(250);
        write_width('0);
        idle_pct = 0;
        run_random(200);
        wait_idle();
        idle_pct = 26;
        write_width(SW_W'($urandom_range(4096, 1)));
        run_random(200);

        wait_idle();
        repeat (200) @(negedge i_clk);
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
